[src/shdl_pkg.sv]
`timescale 1ns / 1ps
// Package for the decimating sample history log.
// Holds constants, item and log entry types, and controller command/status structs.
// No dependencies.
package shdl_pkg;

    localparam int HISTORY_DEPTH   = 256;
    localparam int DECIMATE_FACTOR = 6;

    localparam int TIME_W     = 32;
    localparam int TEMP_W     = 12;
    localparam int HUM_W      = 10;
    localparam int RIDX_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int INTERVAL_W = 22;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(60000);
    localparam logic [TIME_W-1:0]     GUARD_RST    = 32'd3131922040;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_INTERVAL = 8'd0,
        CFG_TIME_GUARD      = 8'd1
    } t_cfg_idx;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_READ   = 1'b1
    } t_mode;

    typedef struct packed {
        logic                     mode;
        logic [TIME_W-1:0]        now_ms;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
        logic [RIDX_W-1:0]        read_index;
    } t_in_item;

    typedef struct packed {
        logic                     stored;
        logic                     compacted;
        logic [COUNT_W-1:0]       entry_count;
        logic                     read_valid;
        logic [TIME_W-1:0]        read_time;
        logic signed [TEMP_W-1:0] read_temperature;
        logic [HUM_W-1:0]         read_humidity;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]        time_ms;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic eval;
        logic read_issue;
        logic compact_start;
        logic compact_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic need_compact;
        logic compact_done;
        logic out_free;
    } t_sts;

endpackage

[src/shdl_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample history log.
// Depends on shdl_pkg for the item types.
interface shdl_in_if;
    logic               valid;
    logic               ready;
    shdl_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface shdl_out_if;
    logic                valid;
    logic                ready;
    shdl_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface shdl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [shdl_pkg::CFG_IDX_W-1:0]      index;
    logic [shdl_pkg::CFG_DATA_W-1:0]     wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[src/shdl_ctrl.sv]
`timescale 1ns / 1ps
// Controller FSM for the sample history log: sequences accept, evaluate,
// compaction walk and result load. Depends on shdl_pkg.
module shdl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  shdl_pkg::t_sts i_sts,
    output shdl_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EVAL    = 4'b0010,
        S_COMPACT = 4'b0100,
        S_RESULT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.is_read) begin
                    o_cmd.read_issue = 1'b1;
                    n_state          = S_RESULT;
                end else begin
                    o_cmd.eval = 1'b1;
                    if (i_sts.need_compact) begin
                        o_cmd.compact_start = 1'b1;
                        n_state             = S_COMPACT;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_COMPACT: begin
                o_cmd.compact_step = 1'b1;
                if (i_sts.compact_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/shdl_dp.sv]
`timescale 1ns / 1ps
// Datapath for the sample history log: config registers, log memory,
// store decision, compaction address walk and output register. Depends on shdl_pkg.
module shdl_dp #(
    parameter int HISTORY_DEPTH   = shdl_pkg::HISTORY_DEPTH,
    parameter int DECIMATE_FACTOR = shdl_pkg::DECIMATE_FACTOR
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shdl_pkg::t_in_item i_in_data,
    input  shdl_pkg::t_cmd     i_cmd,
    output shdl_pkg::t_sts     o_sts,
    shdl_cfg_if.sink           i_cfg,
    shdl_out_if.source         o_out
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int RW   = $clog2(DECIMATE_FACTOR);
    localparam int KEEP = HISTORY_DEPTH - HISTORY_DEPTH / DECIMATE_FACTOR;

    logic [shdl_pkg::INTERVAL_W-1:0] r_interval;
    logic [shdl_pkg::TIME_W-1:0]     r_guard;
    logic [shdl_pkg::TIME_W-1:0]     r_last;
    logic [CW-1:0]                   r_count;
    shdl_pkg::t_in_item              r_in;
    logic                            r_stored;
    logic                            r_compacted;

    logic [CW-1:0]     r_ci;
    logic [SW-1:0]     r_src;
    logic [RW-1:0]     r_rem;
    logic              r_wr_pend;
    logic [AW-1:0]     r_wr_addr;

    shdl_pkg::t_entry  r_mem [HISTORY_DEPTH];
    shdl_pkg::t_entry  r_rd_data;

    logic                 r_out_valid;
    shdl_pkg::t_out_item  r_out;

    logic [shdl_pkg::TIME_W-1:0] w_elapsed;
    logic                        w_take;
    logic                        w_need_compact;
    logic                        w_step_rd;
    logic [AW-1:0]               w_src_addr;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    shdl_pkg::t_entry            w_wdata;
    logic                        w_re;
    logic [AW-1:0]               w_raddr;
    logic                        w_rvalid;
    shdl_pkg::t_out_item         w_out;

    assign w_elapsed      = r_in.now_ms - r_last;
    assign w_take         = (w_elapsed > shdl_pkg::TIME_W'(r_interval)) && (r_last < r_guard)
                            && (r_count < CW'(HISTORY_DEPTH));
    assign w_need_compact = w_take && (r_count == CW'(HISTORY_DEPTH - 1));
    assign w_step_rd      = i_cmd.compact_step && (r_ci < CW'(KEEP));
    assign w_src_addr     = (r_src >= SW'(HISTORY_DEPTH)) ? AW'(HISTORY_DEPTH - 1)
                                                          : r_src[AW-1:0];

    assign o_sts.is_read      = (r_in.mode == shdl_pkg::MODE_READ);
    assign o_sts.need_compact = w_need_compact;
    assign o_sts.compact_done = (r_ci == CW'(KEEP)) && !r_wr_pend;
    assign o_sts.out_free     = !r_out_valid;

    // config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= shdl_pkg::INTERVAL_RST;
            r_guard    <= shdl_pkg::GUARD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                shdl_pkg::CFG_SAMPLE_INTERVAL: r_interval <= i_cfg.wdata[shdl_pkg::INTERVAL_W-1:0];
                shdl_pkg::CFG_TIME_GUARD:      r_guard    <= i_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    // log state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_last    <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            if (i_cmd.eval && w_take) begin
                r_last  <= r_in.now_ms;
                r_count <= w_need_compact ? CW'(KEEP) : r_count + CW'(1);
            end
            if (i_cmd.compact_start) begin
                r_wr_pend <= 1'b0;
            end else if (i_cmd.compact_step) begin
                r_wr_pend <= w_step_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_data;
        end
        if (i_cmd.eval) begin
            r_stored    <= w_take;
            r_compacted <= w_need_compact;
        end
        if (i_cmd.compact_start) begin
            r_ci  <= '0;
            r_src <= '0;
            r_rem <= '0;
        end else if (w_step_rd) begin
            r_wr_addr <= r_ci[AW-1:0];
            r_ci      <= r_ci + CW'(1);
            if (r_rem == RW'(DECIMATE_FACTOR - 2)) begin
                r_rem <= '0;
                r_src <= r_src + SW'(2);
            end else begin
                r_rem <= r_rem + RW'(1);
                r_src <= r_src + SW'(1);
            end
        end
    end

    // memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = '{time_ms: r_in.now_ms, temperature: r_in.temperature,
                    humidity: r_in.humidity};
        priority if (i_cmd.eval && w_take) begin
            w_we = 1'b1;
        end else if (r_wr_pend) begin
            w_we    = 1'b1;
            w_waddr = r_wr_addr;
            w_wdata = r_rd_data;
        end
    end

    assign w_re    = i_cmd.read_issue || w_step_rd;
    assign w_raddr = i_cmd.read_issue ? AW'(r_in.read_index) : w_src_addr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // result
    assign w_rvalid = (r_in.mode == shdl_pkg::MODE_READ)
                      && (32'(r_in.read_index) < 32'(r_count));

    always_comb begin
        w_out                  = '0;
        w_out.entry_count      = shdl_pkg::COUNT_W'(r_count);
        w_out.read_valid       = w_rvalid;
        if (r_in.mode == shdl_pkg::MODE_SAMPLE) begin
            w_out.stored    = r_stored;
            w_out.compacted = r_compacted;
        end
        if (w_rvalid) begin
            w_out.read_time        = r_rd_data.time_ms;
            w_out.read_temperature = r_rd_data.temperature;
            w_out.read_humidity    = r_rd_data.humidity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= w_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

[src/sample_history_decimating_log_top.sv]
`timescale 1ns / 1ps
// Decimating sample history log, top level. Sample and read items pass through the
// evaluate and result states; the result is registered once the output register is free,
// and the next input is taken after it is loaded. A sample that fills the log adds a
// compaction walk, one entry per cycle through the log memory's read/write pair.
// Synchronous active-low reset clears count, last time and config; log memory is not cleared.
// Depends on shdl_pkg, shdl_if, shdl_ctrl and shdl_dp.
module sample_history_decimating_log_top #(
    parameter int HISTORY_DEPTH   = shdl_pkg::HISTORY_DEPTH,
    parameter int DECIMATE_FACTOR = shdl_pkg::DECIMATE_FACTOR
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    shdl_in_if.sink    i_in,
    shdl_out_if.source o_out,
    shdl_cfg_if.sink   i_cfg
);

    shdl_pkg::t_cmd w_cmd;
    shdl_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_in.ready = w_in_ready;

    shdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    shdl_dp #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .DECIMATE_FACTOR (DECIMATE_FACTOR)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in.data),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

    a_compact_after_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.compacted) |-> o_out.data.stored)
        else $error("compacted result without a store");

    a_read_excl_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.read_valid) |-> (!o_out.data.stored && !o_out.data.compacted))
        else $error("read result carries sample flags");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> w_sts.out_free)
        else $error("result loaded over a pending result");

    a_no_accept_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.compact_step |-> !w_in_ready)
        else $error("input ready during compaction");

endmodule

[tb/sv/sample_log_checker.sv]
`timescale 1ns / 1ps
// Checker for the decimating sample history log: mirrors the log from the input
// and register transfers and compares every result transfer against it in order.
// Depends on shdl_pkg and the channel interfaces in shdl_if.
module sample_log_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    shdl_in_if   i_in,
    shdl_out_if  i_out,
    shdl_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_stored_count,
    output int   o_compact_count,
    output int   o_read_hits
);
    import shdl_pkg::*;

    t_entry                log_mem [HISTORY_DEPTH];
    int unsigned           entries;
    logic [TIME_W-1:0]     last_time;
    logic [INTERVAL_W-1:0] interval;
    logic [TIME_W-1:0]     guard;
    t_out_item             pending_log_replies [$];
    int                    fails     = 0;
    int                    stored_n  = 0;
    int                    compact_n = 0;
    int                    hits_n    = 0;

    assign o_fail_count    = fails;
    assign o_stored_count  = stored_n;
    assign o_compact_count = compact_n;
    assign o_read_hits     = hits_n;

    function automatic t_out_item advance_log(input t_in_item it);
        t_out_item         r;
        logic [TIME_W-1:0] elapsed;
        int unsigned       keep;
        int unsigned       src;
        r = '0;
        if (it.mode == MODE_SAMPLE) begin
            elapsed = it.now_ms - last_time;
            if (elapsed > TIME_W'(interval) && last_time < guard &&
                entries < HISTORY_DEPTH) begin
                last_time                    = it.now_ms;
                log_mem[entries].time_ms     = it.now_ms;
                log_mem[entries].temperature = it.temperature;
                log_mem[entries].humidity    = it.humidity;
                entries++;
                r.stored = 1'b1;
            end
            // full log: drop every DECIMATE_FACTOR-th entry, walking upward in place
            if (entries >= HISTORY_DEPTH) begin
                keep = entries - entries / DECIMATE_FACTOR;
                for (int unsigned i = 0; i < keep; i++) begin
                    src = i * DECIMATE_FACTOR / (DECIMATE_FACTOR - 1);
                    if (src >= HISTORY_DEPTH) begin
                        src = HISTORY_DEPTH - 1;
                    end
                    log_mem[i] = log_mem[src];
                end
                entries     = keep;
                r.compacted = 1'b1;
            end
        end else if (it.read_index < entries) begin
            r.read_valid       = 1'b1;
            r.read_time        = log_mem[it.read_index].time_ms;
            r.read_temperature = log_mem[it.read_index].temperature;
            r.read_humidity    = log_mem[it.read_index].humidity;
        end
        r.entry_count = COUNT_W'(entries);
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t ns", what, got, want, $time);
        fails++;
    endtask

    task automatic compare_reply(input t_out_item got, input t_out_item want);
        if (got.stored !== want.stored) begin
            report("stored", got.stored, want.stored);
        end
        if (got.compacted !== want.compacted) begin
            report("compacted", got.compacted, want.compacted);
        end
        if (got.entry_count !== want.entry_count) begin
            report("entry_count", got.entry_count, want.entry_count);
        end
        if (got.read_valid !== want.read_valid) begin
            report("read_valid", got.read_valid, want.read_valid);
        end
        if (got.read_time !== want.read_time) begin
            report("read_time", got.read_time, want.read_time);
        end
        if (got.read_temperature !== want.read_temperature) begin
            report("read_temperature", got.read_temperature, want.read_temperature);
        end
        if (got.read_humidity !== want.read_humidity) begin
            report("read_humidity", got.read_humidity, want.read_humidity);
        end
    endtask

    always @(posedge i_clk) begin : mirror
        t_out_item want;
        if (!i_rst_n) begin
            entries   = 0;
            last_time = '0;
            interval  = INTERVAL_RST;
            guard     = GUARD_RST;
            pending_log_replies.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_SAMPLE_INTERVAL: interval = i_cfg.wdata[INTERVAL_W-1:0];
                    CFG_TIME_GUARD:      guard    = i_cfg.wdata;
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (pending_log_replies.size() == 0) begin
                    report("result with nothing pending", i_out.data.entry_count, '0);
                end else begin
                    want = pending_log_replies.pop_front();
                    compare_reply(i_out.data, want);
                    stored_n  += want.stored;
                    compact_n += want.compacted;
                    hits_n    += want.read_valid;
                end
            end
            if (i_in.valid && i_in.ready) begin
                pending_log_replies.push_back(advance_log(i_in.data));
            end
        end
        o_outstanding <= pending_log_replies.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the sample history log testbench: clock, reset, directed and random
// sample/read traffic, register phases and the verdict.
// Depends on shdl_pkg, shdl_if, the log top level and sample_log_checker.
module testbench;
    import shdl_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER      = 400;

    typedef enum {GUARD_OPEN, GUARD_SHUT, GUARD_CROSS, GUARD_RANDOM} t_guard_plan;

    logic i_clk;
    logic i_rst_n;

    shdl_in_if  in_ch();
    shdl_out_if out_ch();
    shdl_cfg_if cfg_ch();

    int                fail_count;
    int                outstanding;
    int                stored_count;
    int                compact_count;
    int                read_hits;
    int                items_sent = 0;
    bit                no_idle    = 1'b0;
    logic [TIME_W-1:0] cursor_ms;
    int unsigned       interval_ms;

    sample_history_decimating_log_top DUT (
        .i_clk,
        .i_rst_n,
        .i_in  (in_ch),
        .o_out (out_ch),
        .i_cfg (cfg_ch)
    );

    sample_log_checker log_check (
        .i_clk,
        .i_rst_n,
        .i_in            (in_ch),
        .i_out           (out_ch),
        .i_cfg           (cfg_ch),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_stored_count  (stored_count),
        .o_compact_count (compact_count),
        .o_read_hits     (read_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", outstanding);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_in_item make_item(input t_mode mode, input logic [TIME_W-1:0] now,
                                           input int temp, input int hum, input int idx);
        t_in_item it;
        it.mode        = mode;
        it.now_ms      = now;
        it.temperature = TEMP_W'(temp);
        it.humidity    = HUM_W'(hum);
        it.read_index  = RIDX_W'(idx);
        return it;
    endfunction

    function automatic t_in_item random_sample(input logic [TIME_W-1:0] now);
        return make_item(MODE_SAMPLE, now, int'($urandom_range(0, 1650)) - 400,
                         $urandom_range(0, 1000), $urandom_range(0, 255));
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic write_config(input logic [INTERVAL_W-1:0] interval,
                                input logic [TIME_W-1:0] guard);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_SAMPLE_INTERVAL;
        // upper bits of the interval word are ignored by the block
        cfg_ch.wdata <= {10'($urandom()), interval};
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.index <= CFG_TIME_GUARD;
        cfg_ch.wdata <= guard;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_log();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : result_drain
        int stall;
        int taken;
        bit held;
        taken = 0;
        held  = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            // one long hold so the log backs up and stalls its input
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            taken++;
        end
    end

    initial begin : stimulus
        t_guard_plan       guard_plan [PHASES];
        int unsigned       interval_plan [PHASES];
        logic [TIME_W-1:0] guard_val;
        logic [TIME_W-1:0] now;
        int                pick;

        guard_plan    = '{GUARD_OPEN, GUARD_OPEN, GUARD_OPEN, GUARD_SHUT,
                          GUARD_CROSS, GUARD_OPEN, GUARD_RANDOM, GUARD_OPEN};
        interval_plan = '{1, 0, 3600000, 0, 0, 60000, 0, 1};

        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_SAMPLE_INTERVAL;
        cfg_ch.wdata <= '0;
        i_rst_n      <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty reads, interval boundary, field extremes, guard
        send_item(make_item(MODE_READ, 0, 0, 0, 0));
        send_item(make_item(MODE_READ, 0, 0, 0, 255));
        send_item(make_item(MODE_SAMPLE, 0, 5, 5, 0));
        send_item(make_item(MODE_SAMPLE, 60000, 5, 5, 0));
        send_item(make_item(MODE_SAMPLE, 60001, -400, 0, 0));
        send_item(make_item(MODE_SAMPLE, 120002, 1250, 1000, 255));
        send_item(make_item(MODE_READ, 0, 0, 0, 0));
        send_item(make_item(MODE_READ, 32'hFFFF_FFFF, 0, 0, 1));
        send_item(make_item(MODE_READ, 0, 0, 0, 2));
        send_item(make_item(MODE_SAMPLE, 32'd3131922039, 0, 500, 0));
        send_item(make_item(MODE_SAMPLE, 32'd3131982040, -1, 1, 0));
        send_item(make_item(MODE_SAMPLE, 32'd3132042042, 300, 700, 0));
        send_item(make_item(MODE_READ, 0, 0, 0, 3));
        drain_log();

        // smallest interval, open guard, time wrap
        write_config(INTERVAL_W'(1), '1);
        send_item(make_item(MODE_SAMPLE, 32'hFFFF_FFF0, 100, 200, 0));
        send_item(make_item(MODE_SAMPLE, 32'hFFFF_FFF1, 101, 201, 0));
        send_item(make_item(MODE_SAMPLE, 32'h0000_0005, 102, 202, 0));
        send_item(make_item(MODE_READ, 0, 0, 0, 5));
        send_item(make_item(MODE_SAMPLE, 32'h0000_0006, 103, 203, 0));
        send_item(make_item(MODE_SAMPLE, 32'h0000_0007, 104, 204, 0));
        drain_log();

        for (int p = 0; p < PHASES; p++) begin
            interval_ms = (interval_plan[p] != 0) ? interval_plan[p] : $urandom_range(1, 5000);
            cursor_ms   = (guard_plan[p] == GUARD_CROSS) ? $urandom_range(0, 32'h7FFF_FFFF)
                                                         : $urandom();
            // anchor the last stored time at the cursor with the guard open
            write_config(INTERVAL_W'(interval_ms), '1);
            send_item(random_sample(cursor_ms));
            drain_log();
            case (guard_plan[p])
                GUARD_OPEN:  guard_val = '1;
                GUARD_SHUT:  guard_val = '0;
                GUARD_CROSS: guard_val = cursor_ms + 120 * (interval_ms + 250);
                default:     guard_val = $urandom();
            endcase
            write_config(INTERVAL_W'(interval_ms), guard_val);
            no_idle = (p == 1 || p == 6);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    cursor_ms = cursor_ms + interval_ms + 1 + $urandom_range(0, 500);
                    send_item(random_sample(cursor_ms));
                end else if (pick < 66) begin
                    send_item(random_sample(cursor_ms + interval_ms));
                end else if (pick < 74) begin
                    now = cursor_ms + $urandom_range(0, interval_ms);
                    send_item(random_sample(now));
                end else if (pick < 78) begin
                    send_item(random_sample($urandom()));
                end else begin
                    send_item(make_item(MODE_READ, $urandom(), int'($urandom_range(0, 1650)) - 400,
                                        $urandom_range(0, 1000), $urandom_range(0, 255)));
                end
            end
            no_idle = 1'b0;
            drain_log();
        end

        $display("Run: %0d items over %0d register settings, %0d samples stored,",
                 items_sent, PHASES + 2, stored_count);
        $display("     %0d log compactions, %0d reads of stored entries", compact_count,
                 read_hits);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
